/* src/lru_page_window_table_unit_defines.svh */
`ifndef LRU_PAGE_WINDOW_TABLE_UNIT_DEFINES_SVH
`define LRU_PAGE_WINDOW_TABLE_UNIT_DEFINES_SVH

// check that cons holds in the same cycle as ante
`define LPWT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page window table check failed");

// check that cons holds in the cycle after ante
`define LPWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page window table sequencing check failed");

`endif

/* src/lpwt_pkg.sv */
package lpwt_pkg;

    localparam int ID_W     = 64;
    localparam int OFFSET_W = 48;
    localparam int LENGTH_W = 32;
    localparam int TICK_W   = 64;
    localparam int WIN_W    = 5;
    localparam int IDX_W    = 8;
    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 216;
    localparam int M_USER_W = 3;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_WINDOW = 1'b0;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd16;

    typedef enum logic [1:0] {
        KIND_MAP      = 2'd0,
        KIND_PREFETCH = 2'd1,
        KIND_TOUCH    = 2'd2,
        KIND_UNMAP    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_ENTRY = 2'd1,
        WR_TICK  = 2'd2,
        WR_CLEAR = 2'd3
    } wr_op_t;

    typedef struct packed {
        logic                valid;
        logic [ID_W-1:0]     key;
        logic                match_hit;
        logic [IDX_W-1:0]    match_idx;
        logic [OFFSET_W-1:0] match_offset;
        logic [LENGTH_W-1:0] match_length;
        logic                free_hit;
        logic [IDX_W-1:0]    free_idx;
        logic                lru_hit;
        logic [IDX_W-1:0]    lru_idx;
        logic [TICK_W-1:0]   lru_tick;
        logic [ID_W-1:0]     lru_id;
    } scan_rec_t;

    typedef struct packed {
        wr_op_t              op;
        logic [IDX_W-1:0]    idx;
        logic [ID_W-1:0]     id;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
        logic [TICK_W-1:0]   tick;
    } wr_cmd_t;

endpackage

/* src/lpwt_cell.sv */
module lpwt_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lpwt_pkg::scan_rec_t rec_i,
    output lpwt_pkg::scan_rec_t rec_o,
    input  lpwt_pkg::wr_cmd_t   cmd_i
);

    localparam logic [lpwt_pkg::IDX_W-1:0] MY_IDX = lpwt_pkg::IDX_W'(CELL_INDEX);

    logic                          valid_reg;
    logic [lpwt_pkg::ID_W-1:0]     id_reg;
    logic [lpwt_pkg::OFFSET_W-1:0] offset_reg;
    logic [lpwt_pkg::LENGTH_W-1:0] length_reg;
    logic [lpwt_pkg::TICK_W-1:0]   tick_reg;

    logic                rec_valid_reg;
    lpwt_pkg::scan_rec_t rec_data_reg;
    lpwt_pkg::scan_rec_t rec_next;

    logic sel;
    logic hit;
    logic lru_better;

    assign sel = (cmd_i.idx == MY_IDX);
    assign hit = valid_reg && (id_reg == rec_i.key);
    assign lru_better = valid_reg && (!rec_i.lru_hit || (tick_reg < rec_i.lru_tick) ||
                        ((tick_reg == rec_i.lru_tick) && (id_reg < rec_i.lru_id)));

    always_comb begin
        rec_next = rec_i;
        if (hit && !rec_i.match_hit) begin
            rec_next.match_hit    = 1'b1;
            rec_next.match_idx    = MY_IDX;
            rec_next.match_offset = offset_reg;
            rec_next.match_length = length_reg;
        end
        if (!valid_reg && !rec_i.free_hit) begin
            rec_next.free_hit = 1'b1;
            rec_next.free_idx = MY_IDX;
        end
        if (lru_better) begin
            rec_next.lru_hit  = 1'b1;
            rec_next.lru_idx  = MY_IDX;
            rec_next.lru_tick = tick_reg;
            rec_next.lru_id   = id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            rec_valid_reg <= 1'b0;
        end else begin
            rec_valid_reg <= rec_i.valid;
            if (sel) begin
                case (cmd_i.op)
                    lpwt_pkg::WR_ENTRY: valid_reg <= 1'b1;
                    lpwt_pkg::WR_CLEAR: valid_reg <= 1'b0;
                    default:            valid_reg <= valid_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        rec_data_reg <= rec_next;
        if (sel) begin
            case (cmd_i.op)
                lpwt_pkg::WR_ENTRY: begin
                    id_reg     <= cmd_i.id;
                    offset_reg <= cmd_i.offset;
                    length_reg <= cmd_i.length;
                    tick_reg   <= cmd_i.tick;
                end
                lpwt_pkg::WR_TICK: begin
                    tick_reg <= cmd_i.tick;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rec_o       = rec_data_reg;
        rec_o.valid = rec_valid_reg;
    end

endmodule

/* src/lru_page_window_table_unit.sv */
// channel   dir  tdata (low bit up)                                      tuser (low bit up)
// s_        in   page_id 64, byte_offset 48, byte_length 32              kind 2
// m_        out  result_id 64, hint_offset 48, hint_length 32,           found, hint_valid,
//                evicted_id 64, mapped_count 5, pad 3                    evicted_valid
// apb       in   window_pages at address 0
//
// A request runs from accept to the next accept in these steps: a search record
// walks the cell chain one cell per cycle, then eviction, write and result load.
// Reset is synchronous, clears slot valid bits, next id, tick and count, and sets the
// window to 16.
// A result waits in the output register while m_tready is low; the next request is
// taken once the previous result is loaded there.
`include "lru_page_window_table_unit_defines.svh"

module lru_page_window_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpwt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [lpwt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [lpwt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // page_id, byte_offset, byte_length
    input  logic [lpwt_pkg::S_DATA_W-1:0]     s_tdata,
    // kind
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_id, hint_offset, hint_length, evicted_id, mapped_count, zero pad
    output logic [lpwt_pkg::M_DATA_W-1:0]     m_tdata,
    // found, hint_valid, evicted_valid
    output logic [lpwt_pkg::M_USER_W-1:0]     m_tuser
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > lpwt_pkg::WIN_W) ? CNT_W : lpwt_pkg::WIN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVICT,
        S_WRITE,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic [lpwt_pkg::WIN_W-1:0]    window_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [lpwt_pkg::ID_W-1:0]     next_id_reg;
    logic [lpwt_pkg::TICK_W-1:0]   tick_reg;
    lpwt_pkg::kind_t               kind_reg;
    logic [lpwt_pkg::OFFSET_W-1:0] offset_reg;
    logic [lpwt_pkg::LENGTH_W-1:0] length_reg;
    logic                          head_valid_reg;
    logic [lpwt_pkg::ID_W-1:0]     head_key_reg;
    lpwt_pkg::scan_rec_t           rec_reg;
    logic                          evict_reg;

    logic                          m_tvalid_reg;
    logic [lpwt_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [lpwt_pkg::M_USER_W-1:0] m_tuser_reg;

    lpwt_pkg::scan_rec_t link [TABLE_DEPTH+1];
    lpwt_pkg::wr_cmd_t   cmd;

    logic                 s_accept;
    logic                 cfg_write;
    logic [CMP_W-1:0]     win_ext;
    logic [CMP_W-1:0]     win_eff;
    logic [CMP_W-1:0]     count_ext;
    logic                 is_map;
    logic                 match_ok;
    logic [lpwt_pkg::IDX_W-1:0] target_idx;
    logic                 hint_valid;
    logic                 found;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[lpwt_pkg::CFG_ADDR_W-1] == lpwt_pkg::REG_WINDOW);
    assign prdata    = (paddr[lpwt_pkg::CFG_ADDR_W-1] == lpwt_pkg::REG_WINDOW) ?
                       lpwt_pkg::CFG_DATA_W'(window_reg) : '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign win_ext   = CMP_W'(window_reg);
    assign count_ext = CMP_W'(count_reg);
    assign win_eff   = (win_ext == '0) ? CMP_W'(1) :
                       (win_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : win_ext;

    assign is_map   = (kind_reg == lpwt_pkg::KIND_MAP);
    assign match_ok = rec_reg.match_hit && !(evict_reg && (rec_reg.match_idx == rec_reg.lru_idx));
    assign target_idx = match_ok ? rec_reg.match_idx :
                        (evict_reg && (!rec_reg.free_hit || (rec_reg.lru_idx < rec_reg.free_idx))) ?
                        rec_reg.lru_idx : rec_reg.free_idx;
    assign found      = is_map || rec_reg.match_hit;
    assign hint_valid = (kind_reg == lpwt_pkg::KIND_PREFETCH) && rec_reg.match_hit;

    always_comb begin
        link[0]       = '0;
        link[0].valid = head_valid_reg;
        link[0].key   = head_key_reg;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        lpwt_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .rec_i  (link[i]),
            .rec_o  (link[i+1]),
            .cmd_i  (cmd)
        );
    end

    always_comb begin
        cmd        = '0;
        cmd.op     = lpwt_pkg::WR_NONE;
        cmd.id     = next_id_reg;
        cmd.offset = offset_reg;
        cmd.length = length_reg;
        cmd.tick   = tick_reg;
        case (state_reg)
            S_EVICT: begin
                if (evict_reg) begin
                    cmd.op  = lpwt_pkg::WR_CLEAR;
                    cmd.idx = rec_reg.lru_idx;
                end
            end
            S_WRITE: begin
                case (kind_reg)
                    lpwt_pkg::KIND_MAP: begin
                        cmd.op  = lpwt_pkg::WR_ENTRY;
                        cmd.idx = target_idx;
                    end
                    lpwt_pkg::KIND_UNMAP: begin
                        cmd.idx = rec_reg.match_idx;
                        if (rec_reg.match_hit) begin
                            cmd.op = lpwt_pkg::WR_CLEAR;
                        end
                    end
                    default: begin
                        cmd.idx = rec_reg.match_idx;
                        if (rec_reg.match_hit) begin
                            cmd.op = lpwt_pkg::WR_TICK;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            window_reg     <= lpwt_pkg::WINDOW_RESET;
            count_reg      <= '0;
            next_id_reg    <= '0;
            tick_reg       <= '0;
            head_valid_reg <= 1'b0;
            evict_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_write) begin
                window_reg <= pwdata[lpwt_pkg::WIN_W-1:0];
            end
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            head_valid_reg <= s_accept;
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        kind_reg   <= lpwt_pkg::kind_t'(s_tuser);
                        offset_reg <= s_tdata[111:64];
                        length_reg <= s_tdata[143:112];
                        head_key_reg <= (lpwt_pkg::kind_t'(s_tuser) == lpwt_pkg::KIND_MAP) ?
                                        next_id_reg : s_tdata[63:0];
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (link[TABLE_DEPTH].valid) begin
                        rec_reg   <= link[TABLE_DEPTH];
                        evict_reg <= is_map && (count_ext >= win_eff) && link[TABLE_DEPTH].lru_hit;
                        state_reg <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    if (evict_reg) begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    case (kind_reg)
                        lpwt_pkg::KIND_MAP: begin
                            if (!match_ok) begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                            tick_reg    <= tick_reg + 64'd1;
                            next_id_reg <= next_id_reg + 64'd1;
                        end
                        lpwt_pkg::KIND_UNMAP: begin
                            if (rec_reg.match_hit) begin
                                count_reg <= count_reg - CNT_W'(1);
                            end
                        end
                        default: begin
                            if (rec_reg.match_hit) begin
                                tick_reg <= tick_reg + 64'd1;
                            end
                        end
                    endcase
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'b000, count_ext[4:0],
                                         evict_reg ? rec_reg.lru_id : 64'd0,
                                         hint_valid ? rec_reg.match_length : 32'd0,
                                         hint_valid ? rec_reg.match_offset : 48'd0,
                                         rec_reg.key};
                        m_tuser_reg  <= {evict_reg, hint_valid, found};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `LPWT_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_ext <= CMP_W'(TABLE_DEPTH))
    `LPWT_ASSERT_IMPL(a_tail_in_scan, aclk, aresetn, link[TABLE_DEPTH].valid, state_reg == S_SCAN)
    `LPWT_ASSERT_IMPL(a_evict_nonempty, aclk, aresetn, (state_reg == S_EVICT) && evict_reg, count_reg != '0)
    `LPWT_ASSERT_NEXT(a_accept_scan, aclk, aresetn, s_accept, (state_reg == S_SCAN) && head_valid_reg)

endmodule
